@@ hw/rtl/indexed_deque_store_macros.svh @@
// indexed_deque_store_macros.svh: assertion macros for the deque store
// no dependencies; included by files that carry assertions
`ifndef INDEXED_DEQUE_STORE_MACROS_SVH
`define INDEXED_DEQUE_STORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define IDS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque store check failed");
// next-cycle implication
`define IDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque store check failed");
`else
`define IDS_ASSERT_IMP(label, clk, rst, ante, cons)
`define IDS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/ids_pkg.sv @@
// ids_pkg: types, constants and codes shared by the deque store modules
// no dependencies
`default_nettype none
package ids_pkg;

   localparam int CAPACITY      = 64;
   localparam int ELEMENT_WIDTH = 32;
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int IDX_W         = $clog2(CAPACITY);
   // width for comparing positions against counts
   localparam int CMP_W         = (CNT_W > 8) ? CNT_W : 8;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;
   typedef elem_type [CAPACITY-1:0]  store_type;
   typedef logic [CNT_W-1:0]         count_type;
   typedef logic [CMP_W-1:0]         cmp_type;

   typedef enum logic [3:0] {
      CMD_PUSH_BACK  = 4'd0,
      CMD_POP_BACK   = 4'd1,
      CMD_PUSH_FRONT = 4'd2,
      CMD_POP_FRONT  = 4'd3,
      CMD_GET        = 4'd4,
      CMD_PUT        = 4'd5,
      CMD_INSERT     = 4'd6,
      CMD_REMOVE     = 4'd7,
      CMD_SWAP       = 4'd8,
      CMD_CLEAR      = 4'd9
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // what the row of cells does in the current cycle
   typedef enum logic [2:0] {
      CM_HOLD,
      CM_WRITE,
      CM_OPEN,
      CM_CLOSE,
      CM_SWAP
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      cmp_type       pos;
      cmp_type       pos2;
      cmp_type       count;
      elem_type      wdata;
      elem_type      swap_a;
      elem_type      swap_b;
   } cell_ctl_type;

endpackage
`default_nettype wire

@@ hw/rtl/ids_if.sv @@
// ids_req_if, ids_rsp_if: valid/ready channels of the deque store
// depends on ids_pkg
`default_nettype none
interface ids_req_if;
   logic                    valid;
   logic                    ready;
   logic [3:0]              command;
   logic [7:0]              position;
   logic [7:0]              other_position;
   logic [31:0]             data_in;
   modport source (output valid, command, position, other_position, data_in, input ready);
   modport sink (input valid, command, position, other_position, data_in, output ready);
endinterface

interface ids_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [31:0]             data_out;
   logic [1:0]              status;
   logic [6:0]              element_count;
   modport source (output valid, data_out, status, element_count, input ready);
   modport sink (input valid, data_out, status, element_count, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ids_cell.sv @@
// ids_cell: one storage cell of the deque row, loads from itself, its
// neighbors, the write data, a swap value or zero; depends on ids_pkg
`default_nettype none
module ids_cell (
   input  wire                   clock,
   input  ids_pkg::cmp_type      cell_index,
   input  ids_pkg::cell_ctl_type ctl,
   input  ids_pkg::elem_type     left_value,
   input  ids_pkg::elem_type     right_value,
   output ids_pkg::elem_type     value
);
   import ids_pkg::*;

   elem_type value_ff, value_in;
   cmp_type  next_index;

   assign next_index = cell_index + cmp_type'(1);

   // per-cell next value
   always_comb begin
      value_in = value_ff;
      case (ctl.mode)
         CM_WRITE: begin
            if (cell_index == ctl.pos) value_in = ctl.wdata;
         end
         CM_OPEN: begin
            if (cell_index == ctl.pos) begin
               value_in = ctl.wdata;
            end else if (cell_index > ctl.pos && cell_index <= ctl.count) begin
               value_in = left_value;
            end else if (cell_index >= ctl.count && cell_index < ctl.pos) begin
               value_in = '0;
            end
         end
         CM_CLOSE: begin
            if (cell_index >= ctl.pos && next_index < ctl.count) value_in = right_value;
         end
         CM_SWAP: begin
            if (cell_index == ctl.pos) begin
               value_in = ctl.swap_a;
            end else if (cell_index == ctl.pos2) begin
               value_in = ctl.swap_b;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
endmodule
`default_nettype wire

@@ hw/rtl/ids_ctrl.sv @@
// ids_ctrl: decodes one command into the row control, result and new count
// depends on ids_pkg
`default_nettype none
module ids_ctrl (
   input  wire                   active,
   input  wire [3:0]             command,
   input  wire [7:0]             position,
   input  wire [7:0]             other_position,
   input  wire [31:0]            data_in,
   input  ids_pkg::count_type    count,
   input  ids_pkg::store_type    store,
   output ids_pkg::cell_ctl_type ctl,
   output logic [31:0]           data_out,
   output ids_pkg::status_type   status,
   output ids_pkg::count_type    new_count
);
   import ids_pkg::*;

   cmp_type  cnt, p, p2, rd_addr;
   elem_type rd_a, rd_b;
   logic     full, empty;

   assign cnt   = cmp_type'(count);
   assign p     = cmp_type'(position);
   assign p2    = cmp_type'(other_position);
   assign full  = (count == count_type'(CAPACITY));
   assign empty = (count == '0);

   // read ports into the row
   always_comb begin
      case (cmd_type'(command))
         CMD_POP_BACK:  rd_addr = cnt - cmp_type'(1);
         CMD_POP_FRONT: rd_addr = '0;
         default:       rd_addr = p;
      endcase
   end
   assign rd_a = store[rd_addr[IDX_W-1:0]];
   assign rd_b = store[p2[IDX_W-1:0]];

   // command decode
   always_comb begin
      ctl.mode   = CM_HOLD;
      ctl.pos    = p;
      ctl.pos2   = p2;
      ctl.count  = cnt;
      ctl.wdata  = elem_type'(data_in);
      ctl.swap_a = rd_b;
      ctl.swap_b = rd_a;
      data_out   = '0;
      status     = ST_OK;
      new_count  = count;
      case (cmd_type'(command))
         CMD_PUSH_BACK: begin
            if (full) status = ST_FULL;
            else begin
               ctl.mode  = CM_WRITE;
               ctl.pos   = cnt;
               new_count = count + count_type'(1);
            end
         end
         CMD_POP_BACK: begin
            if (empty) status = ST_RANGE;
            else begin
               data_out  = 32'(rd_a);
               new_count = count - count_type'(1);
            end
         end
         CMD_PUSH_FRONT: begin
            if (full) status = ST_FULL;
            else begin
               ctl.mode  = CM_OPEN;
               ctl.pos   = '0;
               new_count = count + count_type'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (empty) status = ST_RANGE;
            else begin
               ctl.mode  = CM_CLOSE;
               ctl.pos   = '0;
               data_out  = 32'(rd_a);
               new_count = count - count_type'(1);
            end
         end
         CMD_GET: begin
            if (p >= cnt) status = ST_RANGE;
            else data_out = 32'(rd_a);
         end
         CMD_PUT: begin
            if (p >= cnt) status = ST_RANGE;
            else ctl.mode = CM_WRITE;
         end
         CMD_INSERT: begin
            if (p < cnt) begin
               if (full) status = ST_FULL;
               else begin
                  ctl.mode  = CM_OPEN;
                  new_count = count + count_type'(1);
               end
            end else if (p >= cmp_type'(CAPACITY)) begin
               status = ST_FULL;
            end else begin
               // past the end: zero-pad the gap
               ctl.mode  = CM_OPEN;
               new_count = count_type'(p + cmp_type'(1));
            end
         end
         CMD_REMOVE: begin
            if (p >= cnt) status = ST_RANGE;
            else begin
               ctl.mode  = CM_CLOSE;
               data_out  = 32'(rd_a);
               new_count = count - count_type'(1);
            end
         end
         CMD_SWAP: begin
            if (p >= cnt || p2 >= cnt) status = ST_RANGE;
            else ctl.mode = CM_SWAP;
         end
         CMD_CLEAR: new_count = '0;
         default: ;
      endcase
      if (!active) ctl.mode = CM_HOLD;
   end
endmodule
`default_nettype wire

@@ hw/rtl/indexed_deque_store.sv @@
// indexed_deque_store: top level, command register, count, result register
// depends on ids_pkg, ids_if, ids_cell, ids_ctrl, indexed_deque_store_macros.svh
//
// Ordered store of up to CAPACITY elements used as a deque with indexed
// access. Commands arrive on req_chan (push/pop at either end, get, put,
// insert, remove, swap, clear); each one gives exactly one item on rsp_chan
// with data_out, status and element_count after the command.
// An accepted command is first held in the command register and executes
// from there once the response register is free or being taken; its result
// is then loaded into the response register, which drives rsp valid.
// Throughput: one command per cycle while the receiver takes each result.
// Every cell of the row loads its new value in the execute cycle, shifting
// left or right in parallel, so insert, remove and front operations do not step through the cells one at a time.
// Reset clears the element count and both valid flags; cell contents are
// undefined until written and are never read beyond the count.
// When the receiver stalls, the result stays in the response register and
// one further command waits in the command register; req ready then drops.
`default_nettype none
`include "indexed_deque_store_macros.svh"
module indexed_deque_store (
   input  wire        clock,
   input  wire        reset,
   ids_req_if.sink    req_chan,
   ids_rsp_if.source  rsp_chan
);
   import ids_pkg::*;

   // command register
   logic         cmd_valid_ff, cmd_valid_in;
   logic [3:0]   command_ff;
   logic [7:0]   position_ff, other_position_ff;
   logic [31:0]  data_in_ff;

   // state and result register
   count_type    fill_count_ff, fill_count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  rsp_data_ff;
   status_type   rsp_status_ff;
   count_type    rsp_count_ff;

   logic         exec;
   logic         accept;
   cell_ctl_type ctl;
   logic [31:0]  data_out;
   status_type   status;
   count_type    new_count;
   store_type    store;

   // handshake
   assign exec           = cmd_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !cmd_valid_ff || exec;
   assign accept         = req_chan.valid && req_chan.ready;
   assign cmd_valid_in   = accept || (cmd_valid_ff && !exec);
   assign rsp_valid_in   = exec || (rsp_valid_ff && !rsp_chan.ready);
   assign fill_count_in  = exec ? new_count : fill_count_ff;

   // decode
   ids_ctrl u_ctrl (
      .active         (exec),
      .command        (command_ff),
      .position       (position_ff),
      .other_position (other_position_ff),
      .data_in        (data_in_ff),
      .count          (fill_count_ff),
      .store          (store),
      .ctl            (ctl),
      .data_out       (data_out),
      .status         (status),
      .new_count      (new_count)
   );

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      elem_type left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_left
         assign left_v = store[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_right
         assign right_v = store[i+1];
      end
      ids_cell u_cell (
         .clock       (clock),
         .cell_index  (cmp_type'(i)),
         .ctl         (ctl),
         .left_value  (left_v),
         .right_value (right_v),
         .value       (store[i])
      );
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fill_count_ff <= '0;
      end else begin
         cmd_valid_ff  <= cmd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fill_count_ff <= fill_count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff        <= req_chan.command;
         position_ff       <= req_chan.position;
         other_position_ff <= req_chan.other_position;
         data_in_ff        <= req_chan.data_in;
      end
      if (exec) begin
         rsp_data_ff   <= data_out;
         rsp_status_ff <= status;
         rsp_count_ff  <= new_count;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data_out      = rsp_data_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.element_count = 7'(rsp_count_ff);

   // checks
   `IDS_ASSERT_IMP(a_count_matches, clock, reset, rsp_valid_ff, rsp_count_ff == fill_count_ff)
   `IDS_ASSERT_NEXT(a_clear_empties, clock, reset, exec && command_ff == CMD_CLEAR, fill_count_ff == '0)
   `IDS_ASSERT_NEXT(a_full_keeps_count, clock, reset, exec && status == ST_FULL, fill_count_ff == $past(fill_count_ff))
endmodule
`default_nettype wire

@@ sim/ids_tb_pkg.sv @@
`timescale 1ns / 100ps
// ids_tb_pkg: deque mirror that predicts and checks the responses of the deque store
// depends on ids_pkg
package ids_tb_pkg;
   import ids_pkg::*;

   localparam logic [3:0] CMD_FIRST_UNUSED = 4'(CMD_CLEAR) + 4'd1;
   localparam logic [3:0] CMD_LAST_UNUSED  = 4'hF;
   localparam int         REPORT_LIMIT     = 10;

   typedef struct {
      logic [31:0] data_out;
      status_type  status;
      logic [6:0]  element_count;
   } deque_response_type;

   class deque_mirror;
      elem_type           cells [CAPACITY];
      int unsigned        fill;
      deque_response_type pending [$];
      int unsigned        mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      // apply one accepted command to the mirror and queue its response
      function void note_command(logic [3:0] command, logic [7:0] position,
                                 logic [7:0] other_position, logic [31:0] data_in);
         int unsigned        p;
         int unsigned        q;
         int unsigned        k;
         elem_type           value;
         elem_type           held;
         deque_response_type r;
         p     = position;
         q     = other_position;
         value = data_in[ELEMENT_WIDTH-1:0];
         held  = '0;
         r.status = ST_OK;
         case (command)
            CMD_PUSH_BACK: begin
               if (fill >= CAPACITY) r.status = ST_FULL;
               else begin
                  cells[fill] = value;
                  fill++;
               end
            end
            CMD_POP_BACK: begin
               if (fill == 0) r.status = ST_RANGE;
               else begin
                  fill--;
                  held = cells[fill];
               end
            end
            CMD_PUSH_FRONT: begin
               if (fill >= CAPACITY) r.status = ST_FULL;
               else begin
                  for (k = fill; k > 0; k--) cells[k] = cells[k-1];
                  cells[0] = value;
                  fill++;
               end
            end
            CMD_POP_FRONT: begin
               if (fill == 0) r.status = ST_RANGE;
               else begin
                  held = cells[0];
                  for (k = 0; k + 1 < fill; k++) cells[k] = cells[k+1];
                  fill--;
               end
            end
            CMD_GET: begin
               if (p >= fill) r.status = ST_RANGE;
               else held = cells[p];
            end
            CMD_PUT: begin
               if (p >= fill) r.status = ST_RANGE;
               else cells[p] = value;
            end
            CMD_INSERT: begin
               if (p < fill) begin
                  if (fill >= CAPACITY) r.status = ST_FULL;
                  else begin
                     for (k = fill; k > p; k--) cells[k] = cells[k-1];
                     cells[p] = value;
                     fill++;
                  end
               end else if (p + 1 > CAPACITY) begin
                  r.status = ST_FULL;
               end else begin
                  // gap past the old end is padded with null items
                  for (k = fill; k < p; k++) cells[k] = '0;
                  cells[p] = value;
                  fill = p + 1;
               end
            end
            CMD_REMOVE: begin
               if (p >= fill) r.status = ST_RANGE;
               else begin
                  held = cells[p];
                  for (k = p; k + 1 < fill; k++) cells[k] = cells[k+1];
                  fill--;
               end
            end
            CMD_SWAP: begin
               if (p >= fill || q >= fill) r.status = ST_RANGE;
               else begin
                  held     = cells[p];
                  cells[p] = cells[q];
                  cells[q] = held;
                  held     = '0;
               end
            end
            CMD_CLEAR: fill = 0;
            default: ;
         endcase
         r.data_out      = 32'(held);
         r.element_count = 7'(fill);
         pending.push_back(r);
      endfunction

      // compare one accepted response with the oldest pending one
      function void check_response(logic [31:0] data_out, logic [1:0] status,
                                   logic [6:0] element_count);
         deque_response_type r;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected response data %h status %0d count %0d",
                        $time, data_out, status, element_count);
         end else begin
            r = pending.pop_front();
            if (data_out !== r.data_out || status !== 2'(r.status) ||
                element_count !== r.element_count) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("%0t: response mismatch: expected data %h status %0d count %0d",
                           $time, r.data_out, r.status, r.element_count);
                  $display("%0t:    got data %h status %0d count %0d",
                           $time, data_out, status, element_count);
               end
            end
         end
      endfunction
   endclass

endpackage

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// tb: drives random and directed commands into indexed_deque_store and checks every response
// depends on ids_pkg, ids_if, ids_tb_pkg and the store's rtl
module tb;
   import ids_pkg::*;
   import ids_tb_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 1750;

   logic clock;
   logic reset;

   ids_req_if req_chan ();
   ids_rsp_if rsp_chan ();

   indexed_deque_store DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deque_mirror mirror = new();

   bit          req_calm;
   bit          rsp_calm;
   int unsigned rsp_stall_left;
   int unsigned rsp_span_left;
   int unsigned idle_cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gap length: mostly none, some short, a few long
   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      r = $urandom_range(99);
      if (calm || r < 70) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(24, 5);
   endfunction

   // command mix, biased toward filling or draining the store
   function automatic logic [3:0] choose_command(bit grow);
      logic [3:0]  codes [10] = '{CMD_PUSH_BACK, CMD_POP_BACK, CMD_PUSH_FRONT,
                                  CMD_POP_FRONT, CMD_GET, CMD_PUT, CMD_INSERT,
                                  CMD_REMOVE, CMD_SWAP, CMD_CLEAR};
      int unsigned grow_mix  [11] = '{180, 60, 120, 60, 140, 100, 130, 80, 100, 10, 20};
      int unsigned drain_mix [11] = '{60, 170, 40, 150, 130, 90, 50, 190, 90, 10, 20};
      int unsigned r;
      int unsigned w;
      r = $urandom_range(999);
      for (int k = 0; k < 10; k++) begin
         w = grow ? grow_mix[k] : drain_mix[k];
         if (r < w) return codes[k];
         r -= w;
      end
      return 4'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
   endfunction

   // positions mostly inside the store, some just past the end, some anywhere
   function automatic logic [7:0] choose_position(logic [3:0] command);
      int unsigned r;
      r = $urandom_range(99);
      if (r < 10) return 8'($urandom_range(255));
      if (command == CMD_INSERT && r < 30) return 8'(mirror.fill + $urandom_range(4));
      if (r < 90 && mirror.fill != 0) return 8'($urandom_range(mirror.fill - 1));
      return 8'($urandom_range(mirror.fill + 2));
   endfunction

   function automatic logic [31:0] choose_data();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      return $urandom;
   endfunction

   // present one item and hold it until accepted
   task automatic send_command(logic [3:0] command, logic [7:0] position,
                               logic [7:0] other_position, logic [31:0] data_in);
      int unsigned gap;
      gap = pick_gap(req_calm);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.command        <= command;
      req_chan.position       <= position;
      req_chan.other_position <= other_position;
      req_chan.data_in        <= data_in;
      do @(posedge clock); while (!req_chan.ready);
      mirror.note_command(command, position, other_position, data_in);
   endtask

   // corner cases: empty store, range errors, padding insert, full store
   task automatic run_directed();
      send_command(CMD_POP_BACK, 8'd0, 8'd0, 32'h0);
      send_command(CMD_POP_FRONT, 8'd0, 8'd0, 32'h0);
      send_command(CMD_REMOVE, 8'd0, 8'd0, 32'h0);
      send_command(CMD_GET, 8'd0, 8'd0, 32'h0);
      send_command(CMD_PUT, 8'd0, 8'd0, 32'h1);
      send_command(CMD_SWAP, 8'd0, 8'd0, 32'h0);
      send_command(CMD_PUSH_BACK, 8'd0, 8'd0, 32'hFFFF_FFFF);
      send_command(CMD_PUSH_FRONT, 8'd0, 8'd0, 32'h0);
      send_command(CMD_PUSH_BACK, 8'd255, 8'd255, 32'h8000_0001);
      send_command(CMD_GET, 8'd2, 8'd0, 32'h0);
      send_command(CMD_GET, 8'd255, 8'd0, 32'h0);
      send_command(CMD_PUT, 8'd1, 8'd0, 32'h1234_5678);
      send_command(CMD_INSERT, 8'd1, 8'd0, 32'hA5A5_A5A5);
      send_command(CMD_INSERT, 8'd9, 8'd0, 32'h5A5A_5A5A);
      send_command(CMD_GET, 8'd6, 8'd0, 32'h0);
      send_command(CMD_REMOVE, 8'd9, 8'd0, 32'h0);
      send_command(CMD_SWAP, 8'd0, 8'd3, 32'h0);
      send_command(CMD_SWAP, 8'd2, 8'd2, 32'h0);
      send_command(CMD_SWAP, 8'd1, 8'd200, 32'h0);
      send_command(CMD_INSERT, 8'd255, 8'd0, 32'h1);
      send_command(CMD_INSERT, 8'(CAPACITY - 1), 8'd0, 32'h7);
      send_command(CMD_PUSH_BACK, 8'd0, 8'd0, 32'h2);
      send_command(CMD_PUSH_FRONT, 8'd0, 8'd0, 32'h3);
      send_command(CMD_INSERT, 8'd5, 8'd0, 32'h4);
      send_command(CMD_INSERT, 8'(CAPACITY), 8'd0, 32'h5);
      send_command(CMD_LAST_UNUSED, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
      send_command(CMD_POP_FRONT, 8'd0, 8'd0, 32'h0);
      send_command(CMD_CLEAR, 8'd0, 8'd0, 32'h0);
      send_command(CMD_POP_BACK, 8'd0, 8'd0, 32'h0);
   endtask

   // random commands that swing the fill level between empty and full
   task automatic run_random(int unsigned items);
      bit         grow;
      logic [3:0] command;
      grow = 1'b1;
      for (int unsigned n = 0; n < items; n++) begin
         if (n % 150 == 0) req_calm = ($urandom_range(3) == 0);
         if (mirror.fill >= 60 && $urandom_range(9) < 3) grow = 1'b0;
         else if (mirror.fill <= 2) grow = 1'b1;
         command = choose_command(grow);
         send_command(command, choose_position(command), choose_position(command),
                      choose_data());
      end
   endtask

   // response side: random stalls with calm stretches
   always @(posedge clock) begin
      if (rsp_span_left == 0) begin
         rsp_calm      = ($urandom_range(3) == 0);
         rsp_span_left = $urandom_range(300, 50);
      end else begin
         rsp_span_left--;
      end
      if (rsp_stall_left != 0) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!rsp_calm && $urandom_range(99) < 30) rsp_stall_left = pick_gap(1'b0);
      end
   end

   // check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         mirror.check_response(rsp_chan.data_out, rsp_chan.status, rsp_chan.element_count);
   end

   // watchdog on cycles without any item moving
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
         end
      end
   end

   // reset, stimulus, drain and verdict
   initial begin
      reset                   = 1'b1;
      req_chan.valid          = 1'b0;
      req_chan.command        = '0;
      req_chan.position       = '0;
      req_chan.other_position = '0;
      req_chan.data_in        = '0;
      rsp_chan.ready          = 1'b0;
      req_calm                = 1'b0;
      rsp_calm                = 1'b0;
      rsp_stall_left          = 0;
      rsp_span_left           = 0;
      idle_cycles             = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random(RANDOM_ITEMS);
      req_chan.valid <= 1'b0;
      while (mirror.pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/ids_pkg.sv
hw/rtl/ids_if.sv
hw/rtl/ids_cell.sv
hw/rtl/ids_ctrl.sv
hw/rtl/indexed_deque_store.sv
sim/ids_tb_pkg.sv
sim/tb.sv
